>>> src/lfu_cache_lru_tiebreak_assert.svh
// Assertion macros shared by the cache RTL.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define LFUC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache assertion failed in the same cycle");

// Consequent in the cycle after the antecedent.
`define LFUC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache assertion failed one cycle later");

`endif

>>> src/lfuc_pkg.sv
`timescale 1ns / 1ps

package lfuc_pkg;

    // Request codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Result of one request as held in the output register.
    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } result_t;

endpackage

>>> src/lfu_cache_lru_tiebreak.sv
`timescale 1ns / 1ps

// Fully associative key/value cache with least-frequently-used replacement
// and least-recently-used tie-break.
// The request channel (in_valid, in_stall, operation, key, value) carries a
// get or a put; the result channel (out_valid, out_stall, hit, read_value,
// evicted, evicted_key) returns exactly one result per request.
// A transfer happens at a rising edge where valid is high and stall is low.
// A request passes through a scan, a tail state and an update state: one
// sequencer walks the entries one per cycle through the registered read port
// of the key, data and count memories, the tail state compares the last
// entry read, the update state commits, and the result is then offered. The
// earliest result transfer and the next request transfer fall in the same cycle.
// The block takes one request at a time; in_stall is high while a request is
// in progress. The result sits in an output register, so the next request
// can be taken while an earlier result still waits for its transfer.
// If the receiver stalls, the update cycle waits until the output register
// is free, and no state changes until then.
// Reset clears all valid bits and sets the capacity register to 16; key, data
// and count memories need no clearing pass because only valid entries are
// ever examined. The user must write the capacity register through cfg_wr_en
// and cfg_wr_data while the block is idle (unenforced); zero behaves as one.
module lfu_cache_lru_tiebreak
    import lfuc_pkg::*;
#(
    parameter int ENTRIES     = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] read_value,
    output logic               evicted,
    output logic signed [31:0] evicted_key
);

`include "lfu_cache_lru_tiebreak_assert.svh"

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    // Control state.
    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic               pipe_vld_reg;
    logic [IDX_W-1:0]   pipe_idx_reg;
    logic               found_v_reg;
    logic               victim_v_reg;
    logic               free_v_reg;
    logic [FILL_W-1:0]  filled_reg;
    logic               out_valid_reg;
    logic [4:0]         capacity_reg;
    logic [ENTRIES-1:0] valid_reg;

    // Request and scan payload.
    logic                   op_reg;
    logic [31:0]            key_reg;
    logic [31:0]            value_reg;
    logic [IDX_W-1:0]       found_idx_reg;
    logic [31:0]            found_data_reg;
    logic [COUNT_WIDTH-1:0] found_count_reg;
    logic [IDX_W-1:0]       found_rank_reg;
    logic [IDX_W-1:0]       victim_idx_reg;
    logic [31:0]            victim_key_reg;
    logic [COUNT_WIDTH-1:0] victim_count_reg;
    logic [IDX_W-1:0]       victim_rank_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    result_t                res_reg;

    // Entry storage. Ranks live in flip-flops because a use moves many of
    // them at once; everything else is a memory with one registered read.
    logic [31:0]            key_mem   [ENTRIES];
    logic [31:0]            data_mem  [ENTRIES];
    logic [COUNT_WIDTH-1:0] count_mem [ENTRIES];
    logic [IDX_W-1:0]       rank_reg  [ENTRIES];
    logic [31:0]            key_rd_reg;
    logic [31:0]            data_rd_reg;
    logic [COUNT_WIDTH-1:0] count_rd_reg;

    logic                   accept;
    logic                   commit;
    logic                   cur_valid;
    logic [IDX_W-1:0]       cur_rank;
    logic                   better;
    logic                   is_put;
    logic [4:0]             cap_z;
    logic                   need_evict;
    logic                   do_fill;
    logic                   touch;
    logic [IDX_W-1:0]       slot;
    logic [IDX_W-1:0]       tgt;
    logic                   rank_all;
    logic [IDX_W-1:0]       thr;
    logic [COUNT_WIDTH-1:0] count_wdata;
    result_t                res_next;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign commit   = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);

    // Compare unit for the scan: current entry against the best victim so far.
    assign cur_valid = valid_reg[pipe_idx_reg];
    assign cur_rank  = rank_reg[pipe_idx_reg];
    assign better    = !victim_v_reg || (count_rd_reg < victim_count_reg) ||
                       ((count_rd_reg == victim_count_reg) && (cur_rank > victim_rank_reg));

    // Update decision, made once the scan is complete.
    always_comb
    begin
        is_put     = (op_reg == OP_PUT);
        cap_z      = (capacity_reg == 5'd0) ? 5'd1 : capacity_reg;
        need_evict = ((CMP_W'(filled_reg) >= CMP_W'(cap_z)) || !free_v_reg) && victim_v_reg;
        do_fill    = !found_v_reg && is_put && (need_evict || free_v_reg);
        touch      = found_v_reg || do_fill;
        slot       = need_evict ? victim_idx_reg : free_idx_reg;
        tgt        = found_v_reg ? found_idx_reg : slot;
        // A fresh fill into a free entry ages every valid entry; a hit or an
        // eviction only ages the entries that were newer than the one moved.
        rank_all   = !found_v_reg && !need_evict;
        thr        = found_v_reg ? found_rank_reg : victim_rank_reg;
        if (found_v_reg)
        begin
            count_wdata = (found_count_reg == {COUNT_WIDTH{1'b1}}) ?
                          found_count_reg : found_count_reg + 1'b1;
        end
        else
        begin
            count_wdata = COUNT_WIDTH'(1);
        end
        res_next.hit         = found_v_reg;
        res_next.read_value  = (found_v_reg && !is_put) ? found_data_reg : 32'd0;
        res_next.evicted     = !found_v_reg && is_put && need_evict;
        res_next.evicted_key = res_next.evicted ? victim_key_reg : 32'd0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_idx_reg  <= '0;
            found_v_reg   <= 1'b0;
            victim_v_reg  <= 1'b0;
            free_v_reg    <= 1'b0;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= 5'd16;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pipe_vld_reg <= (state_reg == S_SCAN);
            pipe_idx_reg <= idx_reg;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                idx_reg      <= '0;
                found_v_reg  <= 1'b0;
                victim_v_reg <= 1'b0;
                free_v_reg   <= 1'b0;
                filled_reg   <= '0;
            end
            else if ((state_reg == S_SCAN) && (idx_reg != IDX_W'(ENTRIES - 1)))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (pipe_vld_reg)
            begin
                if (cur_valid)
                begin
                    filled_reg <= filled_reg + 1'b1;
                    if (key_rd_reg == key_reg)
                    begin
                        found_v_reg <= 1'b1;
                    end
                    victim_v_reg <= 1'b1;
                end
                else
                begin
                    free_v_reg <= 1'b1;
                end
            end
            if (commit && do_fill)
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload captured during the scan and the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            value_reg <= value;
        end
        if (pipe_vld_reg && cur_valid)
        begin
            if (key_rd_reg == key_reg && !found_v_reg)
            begin
                found_idx_reg   <= pipe_idx_reg;
                found_data_reg  <= data_rd_reg;
                found_count_reg <= count_rd_reg;
                found_rank_reg  <= cur_rank;
            end
            if (better)
            begin
                victim_idx_reg   <= pipe_idx_reg;
                victim_key_reg   <= key_rd_reg;
                victim_count_reg <= count_rd_reg;
                victim_rank_reg  <= cur_rank;
            end
        end
        if (pipe_vld_reg && !cur_valid && !free_v_reg)
        begin
            free_idx_reg <= pipe_idx_reg;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    // Recency ranks: on a committed use the used entry goes to rank zero and the aging valid entries move up.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (commit && touch)
            begin
                if (tgt == IDX_W'(i))
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (rank_all || rank_reg[i] < thr))
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
    end

    // Entry memories: one read address (the scan index), one write address.
    always_ff @(posedge clk)
    begin
        key_rd_reg   <= key_mem[idx_reg];
        data_rd_reg  <= data_mem[idx_reg];
        count_rd_reg <= count_mem[idx_reg];
        if (commit && touch)
        begin
            count_mem[tgt] <= count_wdata;
        end
        if (commit && do_fill)
        begin
            key_mem[tgt] <= key_reg;
        end
        if (commit && (do_fill || (found_v_reg && is_put)))
        begin
            data_mem[tgt] <= value_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = res_reg.hit;
    assign read_value  = $signed(res_reg.read_value);
    assign evicted     = res_reg.evicted;
    assign evicted_key = $signed(res_reg.evicted_key);

    // An eviction only happens on a miss, and a returned value only on a hit.
    `LFUC_ASSERT_SAME(a_evict_on_miss, clk, rst_n, out_valid_reg && res_reg.evicted, !res_reg.hit)
    `LFUC_ASSERT_SAME(a_value_on_hit, clk, rst_n, out_valid_reg && (res_reg.read_value != 32'd0),
                      res_reg.hit)
    // Entries are only ever replaced, never dropped, so the fill never shrinks.
    `LFUC_ASSERT_NEXT(a_fill_keeps, clk, rst_n, 1'b1,
                      $countones(valid_reg) >= $countones($past(valid_reg)))

endmodule
